// File: rtl/core/mdr_pkg.sv
package mdr_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned WordW   = 16;
    localparam int unsigned SelW    = 4;
    localparam int unsigned MulSteps = 8;
    localparam int unsigned DivSteps = 16;
    localparam int unsigned CntW    = $clog2(DivSteps);

    // register selector codes
    localparam logic [SelW-1:0] SEL_MCAND   = 4'd0;
    localparam logic [SelW-1:0] SEL_MPLIER  = 4'd1;
    localparam logic [SelW-1:0] SEL_DVD_LO  = 4'd2;
    localparam logic [SelW-1:0] SEL_DVD_HI  = 4'd3;
    localparam logic [SelW-1:0] SEL_DIVISOR = 4'd4;
    localparam logic [SelW-1:0] SEL_QUOT_LO = 4'd5;
    localparam logic [SelW-1:0] SEL_QUOT_HI = 4'd6;
    localparam logic [SelW-1:0] SEL_RES_LO  = 4'd7;
    localparam logic [SelW-1:0] SEL_RES_HI  = 4'd8;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [WordW-1:0] QUOT_DIV_ZERO = 16'hFFFF;

    typedef struct packed {
        logic            func;
        logic [SelW-1:0] reg_sel;
        logic [ByteW-1:0] wdata;
    } t_mdr_in;

    typedef struct packed {
        logic [ByteW-1:0] rdata;
        logic             bad_access;
    } t_mdr_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV
    } t_mdr_state;

    typedef struct packed {
        logic busy;
        logic mul_step;
        logic div_step;
    } t_mdr_ctl;

endpackage

// File: rtl/core/mdr_alu.sv
module mdr_alu (
    input  logic [mdr_pkg::ByteW:0]   i_a,
    input  logic [mdr_pkg::ByteW-1:0] i_b,
    input  logic                      i_sub,
    output logic [mdr_pkg::ByteW+1:0] o_res
);
    import mdr_pkg::*;

    logic [ByteW+1:0] a_ext;
    logic [ByteW+1:0] b_ext;

    assign a_ext = {1'b0, i_a};
    assign b_ext = {2'b00, i_b};

    // top bit is the borrow on subtract; it stays clear on add
    always_comb begin
        if (i_sub) begin
            o_res = a_ext - b_ext;
        end else begin
            o_res = a_ext + b_ext;
        end
    end

endmodule

// File: rtl/core/mdr_ctrl.sv
module mdr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start_mul,
    input  logic              i_start_div,
    output mdr_pkg::t_mdr_ctl o_ctl
);
    import mdr_pkg::*;

    t_mdr_state r_state;
    t_mdr_state n_state;
    logic [CntW-1:0] r_cnt;
    logic [CntW-1:0] n_cnt;
    logic last_step;

    assign last_step = ((r_state == ST_MUL) && (r_cnt == CntW'(MulSteps - 1))) ||
                       ((r_state == ST_DIV) && (r_cnt == CntW'(DivSteps - 1)));

    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            ST_IDLE: begin
                if (i_start_mul) begin
                    n_state = ST_MUL;
                end else if (i_start_div) begin
                    n_state = ST_DIV;
                end
            end
            ST_MUL, ST_DIV: begin
                if (last_step) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        unique case (r_state)
            ST_IDLE: o_ctl = '0;
            ST_MUL: begin
                o_ctl.busy     = 1'b1;
                o_ctl.mul_step = 1'b1;
            end
            ST_DIV: begin
                o_ctl.busy     = 1'b1;
                o_ctl.div_step = 1'b1;
            end
            default: o_ctl = '0;
        endcase
    end

    always_comb begin
        if ((r_state == ST_IDLE) || last_step) begin
            n_cnt = '0;
        end else begin
            n_cnt = r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_cnt == '0))
        else $error("step counter not cleared while idle");

    a_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctl.mul_step, o_ctl.div_step}))
        else $error("multiply and divide steps at once");

    a_mul_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_cnt < CntW'(MulSteps)))
        else $error("multiply ran past its step count");

endmodule

// File: rtl/core/multiply_divide_register_unit_top.sv
// byte-wide register-mapped unsigned multiply/divide unit
//
// input channel: one bus transaction per item (func, reg_sel, wdata) on
// i_in_valid / o_in_stall. output channel: one result per transaction
// (rdata, bad_access) on o_out_valid / i_out_stall.
// every result is registered and appears in the cycle after its transaction
// is taken; writes and bad accesses return rdata 0.
// a multiplier write runs an 8-step shift-add multiply and a nonzero divisor
// write a 16-step restoring divide, both on one shared 9-bit adder/subtractor,
// one bit per cycle. the input stays stalled while the multiply or divide
// runs, so the next item is taken only once it has finished; all other
// transactions start no operation that stalls the input.
// a divide by zero completes at once (quotient 0xFFFF, remainder = dividend).
// the input is also stalled while a result waits on a stalled receiver.
// reset (synchronous, active low) clears the multiplicand, dividend, quotient
// and result registers to zero and drops o_out_valid, but not r_div or r_out.
module multiply_divide_register_unit_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mdr_pkg::t_mdr_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mdr_pkg::t_mdr_out o_out_data
);
    import mdr_pkg::*;

    logic [ByteW-1:0] r_mcand;
    logic [WordW-1:0] r_dvd;
    logic [WordW-1:0] r_quot;
    logic [WordW-1:0] r_res;
    logic [ByteW-1:0] r_div;
    logic             r_out_valid;
    t_mdr_out         r_out;

    t_mdr_ctl ctl;
    logic accept;
    logic start_mul;
    logic start_div;
    logic ok;
    logic [ByteW-1:0] rd_byte;

    logic [ByteW:0]   alu_a;
    logic [ByteW-1:0] alu_b;
    logic             alu_sub;
    logic [ByteW+1:0] alu_res;
    logic [ByteW:0]   rem_sh;
    logic             borrow;

    assign o_in_stall = ctl.busy || (r_out_valid && i_out_stall);
    assign accept     = i_in_valid && !o_in_stall;

    // decode of the access
    always_comb begin
        ok      = 1'b0;
        rd_byte = '0;
        if (i_in_data.func == FUNC_WRITE) begin
            unique case (i_in_data.reg_sel) inside
                SEL_MCAND, SEL_MPLIER, SEL_DVD_LO, SEL_DVD_HI, SEL_DIVISOR: ok = 1'b1;
                default: ok = 1'b0;
            endcase
        end else begin
            unique case (i_in_data.reg_sel)
                SEL_QUOT_LO: begin
                    ok      = 1'b1;
                    rd_byte = r_quot[ByteW-1:0];
                end
                SEL_QUOT_HI: begin
                    ok      = 1'b1;
                    rd_byte = r_quot[WordW-1:ByteW];
                end
                SEL_RES_LO: begin
                    ok      = 1'b1;
                    rd_byte = r_res[ByteW-1:0];
                end
                SEL_RES_HI: begin
                    ok      = 1'b1;
                    rd_byte = r_res[WordW-1:ByteW];
                end
                default: ok = 1'b0;
            endcase
        end
    end

    assign start_mul = accept && (i_in_data.func == FUNC_WRITE) &&
                       (i_in_data.reg_sel == SEL_MPLIER);
    assign start_div = accept && (i_in_data.func == FUNC_WRITE) &&
                       (i_in_data.reg_sel == SEL_DIVISOR) && (i_in_data.wdata != '0);

    mdr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start_mul (start_mul),
        .i_start_div (start_div),
        .o_ctl       (ctl)
    );

    // shared adder: multiply adds the multiplicand to the upper half,
    // divide subtracts the divisor from the shifted partial remainder
    assign rem_sh = {r_res[ByteW-1:0], r_quot[WordW-1]};

    always_comb begin
        if (ctl.div_step) begin
            alu_a   = rem_sh;
            alu_b   = r_div;
            alu_sub = 1'b1;
        end else begin
            alu_a   = {1'b0, r_res[WordW-1:ByteW]};
            alu_b   = r_mcand;
            alu_sub = 1'b0;
        end
    end

    mdr_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_res (alu_res)
    );

    assign borrow = alu_res[ByteW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcand <= '0;
            r_dvd   <= '0;
            r_quot  <= '0;
            r_res   <= '0;
        end else if (ctl.mul_step) begin
            if (r_res[0]) begin
                r_res <= {alu_res[ByteW:0], r_res[ByteW-1:1]};
            end else begin
                r_res <= {1'b0, r_res[WordW-1:1]};
            end
        end else if (ctl.div_step) begin
            if (borrow) begin
                r_res <= {{ByteW{1'b0}}, rem_sh[ByteW-1:0]};
            end else begin
                r_res <= {{ByteW{1'b0}}, alu_res[ByteW-1:0]};
            end
            r_quot <= {r_quot[WordW-2:0], !borrow};
        end else if (accept && (i_in_data.func == FUNC_WRITE)) begin
            unique case (i_in_data.reg_sel)
                SEL_MCAND: r_mcand <= i_in_data.wdata;
                SEL_MPLIER: begin
                    r_dvd <= {{ByteW{1'b0}}, i_in_data.wdata};
                    r_res <= {{ByteW{1'b0}}, i_in_data.wdata};
                end
                SEL_DVD_LO: r_dvd[ByteW-1:0] <= i_in_data.wdata;
                SEL_DVD_HI: r_dvd[WordW-1:ByteW] <= i_in_data.wdata;
                SEL_DIVISOR: begin
                    if (i_in_data.wdata == '0) begin
                        r_quot <= QUOT_DIV_ZERO;
                        r_res  <= r_dvd;
                    end else begin
                        r_quot <= r_dvd;
                        r_res  <= '0;
                    end
                end
                default: r_res <= r_res;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && start_div) begin
            r_div <= i_in_data.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.rdata      <= ok ? rd_byte : '0;
            r_out.bad_access <= !ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.busy |-> !accept)
        else $error("transaction taken during an operation");

    a_out_from_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(accept))
        else $error("result without a transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_div_quot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.div_step |-> (r_res[WordW-1:ByteW] == '0))
        else $error("partial remainder exceeds a byte");

endmodule
